>>> rtl/wsd_pkg.sv
`timescale 1ns / 1ps
// wsd_pkg: shared types and constants of the WebSocket frame deframer.
// No dependencies; used by the output channel interface, imported by the deframer and the bench.
package wsd_pkg;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;

	// remaining-minus-one counts for the multi-byte header fields
	localparam logic [2:0] CNT_LEN16 = 3'd1;
	localparam logic [2:0] CNT_LEN64 = 3'd7;
	localparam logic [2:0] CNT_KEY   = 3'd3;

	typedef struct packed {
		logic        kind;
		logic [3:0]  frame_opcode;
		logic        was_masked;
		logic [63:0] payload_length;
		logic [7:0]  out_byte;
		logic        frame_last;
	} wsd_result_t;

endpackage

>>> rtl/wsd_if.sv
`timescale 1ns / 1ps
// wsd_in_if / wsd_out_if: valid-ready channels of the deframer.
// Depends on wsd_pkg for the result item type.
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
	logic                valid;
	logic                ready;
	wsd_pkg::wsd_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// websocket_frame_deframer: splits a received byte stream into WebSocket frames.
// Depends on wsd_pkg and the channel interfaces in wsd_if.sv.
//
// channel   dir   item
// in_ch     in    one received byte (in_byte)
// out_ch    out   header result or one unmasked payload byte (wsd_result_t)
//
// One byte is taken every cycle while the output is not stalled; the header or payload result
// is registered in the output register in the cycle after the byte that causes it.
// The 64-bit remaining-length decrement and compare are combinational, ahead of the state registers.
// arst_n clears the parser state and the output valid flag.
// A stalled output holds its result; a new byte is taken in the cycle it leaves.
module websocket_frame_deframer (
	input  logic clk,
	input  logic arst_n,
	wsd_in_if.sink    in_ch,
	wsd_out_if.source out_ch
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_BYTE0,
		PH_BYTE1,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, nxt_phase;
	logic [3:0]  op_q, nxt_op;
	logic        mask_q, nxt_mask;
	logic [2:0]  cnt_q, nxt_cnt;
	logic [63:0] len_q, nxt_len;
	logic [63:0] rem_q, nxt_rem;
	logic [31:0] key_q, nxt_key;
	logic [1:0]  pos_q, nxt_pos;
	logic        out_valid_q;
	wsd_result_t res_q, nxt_res;

	logic        accept;
	logic        emit;
	logic        len_known, fin;
	logic [63:0] known_len, fin_len, len_shift;
	logic [7:0]  b, kbyte;
	logic [6:0]  code;

	assign b         = in_ch.in_byte;
	assign code      = b[6:0];
	assign len_shift = {len_q[55:0], b};
	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign accept       = in_ch.valid && in_ch.ready;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = res_q;

	always_comb begin
		case (pos_q)
			2'd0:    kbyte = key_q[31:24];
			2'd1:    kbyte = key_q[23:16];
			2'd2:    kbyte = key_q[15:8];
			default: kbyte = key_q[7:0];
		endcase
	end

	always_comb begin
		nxt_phase = phase_q;
		nxt_op    = op_q;
		nxt_mask  = mask_q;
		nxt_cnt   = cnt_q;
		nxt_len   = len_q;
		nxt_rem   = rem_q;
		nxt_key   = key_q;
		nxt_pos   = pos_q;
		emit      = 1'b0;
		len_known = 1'b0;
		known_len = len_q;
		fin       = 1'b0;
		fin_len   = len_q;
		nxt_res   = '0;
		case (phase_q)
			PH_BYTE1: begin
				nxt_mask = b[7];
				if (code == LEN_CODE16) begin
					nxt_cnt   = CNT_LEN16;
					nxt_len   = '0;
					nxt_phase = PH_EXTLEN;
				end else if (code == LEN_CODE64) begin
					nxt_cnt   = CNT_LEN64;
					nxt_len   = '0;
					nxt_phase = PH_EXTLEN;
				end else begin
					nxt_len   = {57'd0, code};
					len_known = 1'b1;
					known_len = {57'd0, code};
				end
			end
			PH_EXTLEN: begin
				nxt_len = len_shift;
				nxt_cnt = cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					len_known = 1'b1;
					known_len = len_shift;
				end
			end
			PH_KEY: begin
				nxt_key = {key_q[23:0], b};
				nxt_cnt = cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					fin     = 1'b1;
					fin_len = len_q;
				end
			end
			PH_PAYLOAD: begin
				emit    = 1'b1;
				nxt_pos = pos_q + 2'd1;
				nxt_rem = rem_q - 64'd1;
				nxt_res.kind         = KIND_PAYLOAD;
				nxt_res.frame_opcode = op_q;
				nxt_res.was_masked   = mask_q;
				nxt_res.out_byte     = b ^ kbyte;
				nxt_res.frame_last   = (rem_q == 64'd1);
				if (rem_q == 64'd1) begin
					nxt_phase = PH_BYTE0;
				end
			end
			default: begin
				nxt_op    = b[3:0];
				nxt_phase = PH_BYTE1;
			end
		endcase
		if (len_known) begin
			nxt_key = '0;
			if (nxt_mask) begin
				nxt_phase = PH_KEY;
				nxt_cnt   = CNT_KEY;
			end else begin
				fin     = 1'b1;
				fin_len = known_len;
			end
		end
		if (fin) begin
			emit    = 1'b1;
			nxt_rem = fin_len;
			nxt_pos = 2'd0;
			nxt_res.kind           = KIND_HEADER;
			nxt_res.frame_opcode   = nxt_op;
			nxt_res.was_masked     = nxt_mask;
			nxt_res.payload_length = fin_len;
			nxt_res.frame_last     = (fin_len == 64'd0);
			nxt_phase = (fin_len == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BYTE0;
			op_q        <= '0;
			mask_q      <= 1'b0;
			cnt_q       <= '0;
			len_q       <= '0;
			rem_q       <= '0;
			key_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= nxt_phase;
				op_q        <= nxt_op;
				mask_q      <= nxt_mask;
				cnt_q       <= nxt_cnt;
				len_q       <= nxt_len;
				rem_q       <= nxt_rem;
				key_q       <= nxt_key;
				pos_q       <= nxt_pos;
				out_valid_q <= emit;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= nxt_res;
		end
	end

`ifndef SYNTHESIS
	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_PAYLOAD |=>
			out_valid_q && res_q.kind == KIND_PAYLOAD)
		else $error("payload byte gave no payload result");

	a_empty_header_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_HEADER && res_q.frame_last |->
			res_q.payload_length == 64'd0)
		else $error("last header result with nonzero length");

	a_payload_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
		else $error("payload phase with no bytes remaining");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_BYTE0 |=> phase_q == PH_BYTE1 && !out_valid_q)
		else $error("first header byte mishandled");
`endif

endmodule

>>> bench/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps
// tb_websocket_frame_deframer: self-checking bench for the WebSocket frame deframer.
// Drives directed and random frames, predicts header and payload items in a scoreboard.
// Depends on wsd_pkg, wsd_if.sv and websocket_frame_deframer.sv.
module tb_websocket_frame_deframer;
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		ST_OPCODE,
		ST_LENCODE,
		ST_EXTLEN,
		ST_KEY,
		ST_PAYLOAD
	} parse_state_t;

	typedef enum logic [1:0] {
		ENC_DIRECT,
		ENC_LEN16,
		ENC_LEN64
	} len_enc_t;

	class frame_tracker;
		parse_state_t state = ST_OPCODE;
		logic [3:0]   opcode = '0;
		logic         masked = 1'b0;
		int           hdr_left = 0;
		logic [63:0]  len_acc = '0;
		logic [63:0]  remaining = '0;
		logic [31:0]  key = '0;
		logic [1:0]   key_pos = '0;
		wsd_result_t  due_results[$];
		int           errors = 0;
		int           checked = 0;

		function bit header_done(output wsd_result_t r);
			remaining = len_acc;
			key_pos = '0;
			r.kind = KIND_HEADER;
			r.frame_opcode = opcode;
			r.was_masked = masked;
			r.payload_length = len_acc;
			r.out_byte = '0;
			r.frame_last = (len_acc == 0);
			state = (len_acc == 0) ? ST_OPCODE : ST_PAYLOAD;
			return 1'b1;
		endfunction

		function bit length_done(output wsd_result_t r);
			key = '0;
			r = '0;
			if (masked) begin
				state = ST_KEY;
				hdr_left = 4;
				return 1'b0;
			end
			return header_done(r);
		endfunction

		function void take_byte(logic [7:0] b);
			wsd_result_t r;
			logic [6:0]  code;
			logic [7:0]  k;
			bit          emit;
			emit = 1'b0;
			r = '0;
			case (state)
				ST_OPCODE: begin
					opcode = b[3:0];
					state = ST_LENCODE;
				end
				ST_LENCODE: begin
					masked = b[7];
					code = b[6:0];
					len_acc = '0;
					if (code == LEN_CODE16 || code == LEN_CODE64) begin
						hdr_left = (code == LEN_CODE16) ? 2 : 8;
						state = ST_EXTLEN;
					end else begin
						len_acc = {57'd0, code};
						emit = length_done(r);
					end
				end
				ST_EXTLEN: begin
					len_acc = {len_acc[55:0], b};
					hdr_left--;
					if (hdr_left == 0)
						emit = length_done(r);
				end
				ST_KEY: begin
					key = {key[23:0], b};
					hdr_left--;
					if (hdr_left == 0)
						emit = header_done(r);
				end
				default: begin
					k = key[8 * (3 - key_pos) +: 8];
					key_pos = key_pos + 2'd1;
					remaining = remaining - 64'd1;
					r.kind = KIND_PAYLOAD;
					r.frame_opcode = opcode;
					r.was_masked = masked;
					r.payload_length = '0;
					r.out_byte = b ^ k;
					r.frame_last = (remaining == 0);
					if (remaining == 0)
						state = ST_OPCODE;
					emit = 1'b1;
				end
			endcase
			if (emit)
				due_results.push_back(r);
		endfunction

		function void check_result(wsd_result_t got);
			wsd_result_t exp;
			checked++;
			if (due_results.size() == 0) begin
				$error("unexpected item: kind %0h opcode %0h len %0h", got.kind,
					got.frame_opcode, got.payload_length);
				errors++;
				return;
			end
			exp = due_results.pop_front();
			if (got.kind !== exp.kind) begin
				$error("kind: expected %0h, got %0h", exp.kind, got.kind);
				errors++;
			end
			if (got.frame_opcode !== exp.frame_opcode) begin
				$error("frame_opcode: expected %0h, got %0h", exp.frame_opcode,
					got.frame_opcode);
				errors++;
			end
			if (got.was_masked !== exp.was_masked) begin
				$error("was_masked: expected %0h, got %0h", exp.was_masked, got.was_masked);
				errors++;
			end
			if (got.payload_length !== exp.payload_length) begin
				$error("payload_length: expected %0h, got %0h", exp.payload_length,
					got.payload_length);
				errors++;
			end
			if (got.out_byte !== exp.out_byte) begin
				$error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
				errors++;
			end
			if (got.frame_last !== exp.frame_last) begin
				$error("frame_last: expected %0h, got %0h", exp.frame_last, got.frame_last);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wsd_in_if  in_ch();
	wsd_out_if out_ch();

	frame_tracker tracker = new;

	int burst_left = 0;
	int bytes_sent = 0;

	websocket_frame_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		tracker.take_byte(b);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] head, input logic masked, input len_enc_t enc,
			input logic [63:0] len, input logic [31:0] key, input int n_payload);
		int i;
		send_byte(head);
		case (enc)
			ENC_LEN16: begin
				send_byte({masked, LEN_CODE16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			ENC_LEN64: begin
				send_byte({masked, LEN_CODE64});
				for (i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
			default: send_byte({masked, len[6:0]});
		endcase
		if (masked)
			for (i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		for (i = 0; i < n_payload; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		logic        masked;
		logic [63:0] len;
		len_enc_t    enc;
		int          pick;
		masked = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		enc = ENC_DIRECT;
		if (pick <= 5) begin
			len = 64'($urandom_range(0, 12));
		end else if (pick == 6) begin
			len = 64'($urandom_range(13, 125));
		end else if (pick == 7) begin
			enc = ENC_LEN16;
			len = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 300))
				: 64'($urandom_range(0, 40));
		end else if (pick == 8) begin
			enc = ENC_LEN64;
			len = 64'($urandom_range(0, 40));
		end else begin
			len = '0;
		end
		send_frame(8'($urandom_range(0, 255)), masked, enc, len, $urandom, int'(len));
	endtask

	// receiver ready: random stretches, plus one long hold to back up the input
	initial begin
		int  run_len;
		int  mode;
		int  i;
		bit  held;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && tracker.checked >= 150) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(1, 24);
			for (i = 0; i < run_len; i++) begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= i[0];
					2: out_ch.ready <= 1'($urandom_range(0, 1));
					default: out_ch.ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_result(out_ch.payload);
	end

	initial begin
		int wait_cycles;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty unmasked frame
		send_frame(8'h81, 1'b0, ENC_DIRECT, 64'd0, 32'h0, 0);
		// RSV bits set, masked short payload
		send_frame(8'h70, 1'b1, ENC_DIRECT, 64'd3, 32'hFF00_A55A, 3);
		// non-minimal 16-bit length
		send_frame(8'h02, 1'b0, ENC_LEN16, 64'd1, 32'h0, 1);
		// masked empty frame through the 64-bit length
		send_frame(8'hFF, 1'b1, ENC_LEN64, 64'd0, 32'hFFFF_FFFF, 0);

		while (bytes_sent < 1040)
			send_random_frame();

		// extreme 64-bit length: frame stays open at the end of the run
		send_frame(8'h89, 1'b1, ENC_LEN64, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, 6);
		in_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (tracker.outstanding() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (tracker.outstanding() != 0)
			$error("%0d expected items never arrived", tracker.outstanding());
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/websocket_frame_deframer.sv
bench/tb_websocket_frame_deframer.sv
